>>> sv/xyz_to_color_temperature_assert.svh
// assertion macros for the color temperature block
`ifndef XYZ_TO_COLOR_TEMPERATURE_ASSERT_SVH
`define XYZ_TO_COLOR_TEMPERATURE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define XCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define XCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/xct_pkg.sv
// shared widths, constants and hand-off types of the color temperature pipeline
`default_nettype none
package xct_pkg;
	localparam int CNT_W  = 16;
	localparam int LUX_W  = 16;
	localparam int KEL_W  = 24;
	localparam int FRAC_W = 20;
	localparam int STEPS  = 3;

	// chromaticity divider
	localparam int SUM_W  = CNT_W + 2;
	localparam int CQ_W   = FRAC_W + 1;
	localparam int CH_STG = (CQ_W + STEPS - 1) / STEPS;

	// slope divider, n clamped to +-2^NLIM_SH
	localparam int NLIM_SH = 6;
	localparam int NM_W    = FRAC_W;
	localparam int NQ_W    = FRAC_W + NLIM_SH + 1;
	localparam int ND_STG  = (NQ_W + STEPS - 1) / STEPS;

	// cubic
	localparam int SQ_W  = 2 * NQ_W;
	localparam int N2_W  = SQ_W - FRAC_W;
	localparam int P3_W  = N2_W + NQ_W;
	localparam int N3_W  = P3_W - FRAC_W;
	localparam int T1_W  = NQ_W + 20;
	localparam int T2_W  = N2_W + 19;
	localparam int T3_W  = N3_W + 16;
	localparam int ACC_W = T3_W + 2;
	localparam int B_W   = ACC_W - FRAC_W;
	localparam int C_W   = 28;
	localparam int RECIP_W  = 28;
	localparam int RECIP_SH = 32;
	localparam int PR_W  = C_W + RECIP_W;
	localparam int QE_W  = PR_W - RECIP_SH;
	localparam int P_STG = 8;

	localparam logic [CQ_W-1:0] X_OFF  = CQ_W'(348127);
	localparam logic [CQ_W-1:0] Y_POLE = CQ_W'(194825);
	localparam logic [CQ_W-1:0] Y_MIN  = CQ_W'(195035);
	localparam logic [NQ_W-1:0] NLIM   = NQ_W'(1) << (FRAC_W + NLIM_SH);

	localparam logic [T1_W-1:0]  K1 = T1_W'(682330);
	localparam logic [T2_W-1:0]  K2 = T2_W'(352500);
	localparam logic [T3_W-1:0]  K3 = T3_W'(44900);
	localparam logic [ACC_W-1:0] C0 = ACC_W'(64'd552033 << FRAC_W);
	localparam logic [B_W-1:0]   SAT_B = B_W'(64'd100 << (KEL_W - 1));
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(171798691);
	localparam logic [C_W-1:0]   DIV_Q = C_W'(25);
	localparam logic [KEL_W-1:0] KMAX = {1'b0, {(KEL_W - 1){1'b1}}};
	localparam logic [KEL_W-1:0] KMIN = {1'b1, {(KEL_W - 1){1'b0}}};

	typedef struct packed {
		logic [CQ_W-1:0]  xq;
		logic [CQ_W-1:0]  yq;
		logic             ok;
		logic [LUX_W-1:0] lux;
	} chroma_t;

	typedef struct packed {
		logic [NQ_W-1:0]  mag;
		logic             neg;
		logic             ok;
		logic [LUX_W-1:0] lux;
	} nval_t;
endpackage
`default_nettype wire

>>> sv/xct_chroma.sv
// pipelined divider for the x and y chromaticities
`default_nettype none
module xct_chroma
	import xct_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CNT_W-1:0] xc,
	input  logic [CNT_W-1:0] yc,
	input  logic [CNT_W-1:0] zc,
	input  logic             xv,
	input  logic             zv,
	output logic             out_valid,
	input  logic             out_stall,
	output chroma_t          res
);
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] xr;
		logic [SUM_W-1:0] yr;
		logic [CQ_W-1:0]  xq;
		logic [CQ_W-1:0]  yq;
		logic             xb;
		logic             yb;
		logic             ok;
		logic [LUX_W-1:0] lux;
	} ch_stage_t;

	ch_stage_t        stg_s [0:CH_STG];
	ch_stage_t        nxt   [0:CH_STG];
	logic [CH_STG:0]  vld_s;
	logic [CH_STG:0]  vprev;
	logic [CH_STG+1:0] ld;
	logic [SUM_W-1:0] sum;

	assign sum   = SUM_W'(xc) + SUM_W'(yc) + SUM_W'(zc);
	assign vprev = {vld_s[CH_STG-1:0], in_valid};

	always_comb begin
		ld[CH_STG+1] = !out_stall;
		for (int k = CH_STG; k >= 0; k--) begin
			ld[k] = !vld_s[k] || ld[k+1];
		end
	end

	always_comb begin
		ch_stage_t d;
		logic [SUM_W:0] rx;
		logic [SUM_W:0] ry;
		d  = '0;
		rx = '0;
		ry = '0;
		nxt[0].sum = sum;
		nxt[0].xr  = SUM_W'(xc >> 1);
		nxt[0].yr  = SUM_W'(yc >> 1);
		nxt[0].xq  = '0;
		nxt[0].yq  = '0;
		nxt[0].xb  = xc[0];
		nxt[0].yb  = yc[0];
		nxt[0].ok  = xv && zv && (sum != '0);
		nxt[0].lux = LUX_W'(yc);
		for (int k = 1; k <= CH_STG; k++) begin
			d = stg_s[k-1];
			for (int t = 0; t < STEPS; t++) begin
				if ((k - 1) * STEPS + t < CQ_W) begin
					// low count bit enters on the first step only
					rx = {d.xr, ((k - 1) * STEPS + t == 0) ? d.xb : 1'b0};
					ry = {d.yr, ((k - 1) * STEPS + t == 0) ? d.yb : 1'b0};
					if (rx >= {1'b0, d.sum}) begin
						rx   = rx - {1'b0, d.sum};
						d.xq = {d.xq[CQ_W-2:0], 1'b1};
					end else begin
						d.xq = {d.xq[CQ_W-2:0], 1'b0};
					end
					if (ry >= {1'b0, d.sum}) begin
						ry   = ry - {1'b0, d.sum};
						d.yq = {d.yq[CQ_W-2:0], 1'b1};
					end else begin
						d.yq = {d.yq[CQ_W-2:0], 1'b0};
					end
					d.xr = rx[SUM_W-1:0];
					d.yr = ry[SUM_W-1:0];
				end
			end
			nxt[k] = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k <= CH_STG; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vprev[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k <= CH_STG; k++) begin
			if (ld[k]) begin
				stg_s[k] <= nxt[k];
			end
		end
	end

	assign in_stall  = !ld[0];
	assign out_valid = vld_s[CH_STG];
	assign res.xq    = stg_s[CH_STG].xq;
	assign res.yq    = stg_s[CH_STG].yq;
	assign res.ok    = stg_s[CH_STG].ok;
	assign res.lux   = stg_s[CH_STG].lux;
endmodule
`default_nettype wire

>>> sv/xct_ndiv.sv
// pipelined signed divider for the slope n, clamped to +-64
`default_nettype none
module xct_ndiv
	import xct_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  chroma_t din,
	output logic    out_valid,
	input  logic    out_stall,
	output nval_t   res
);
	typedef struct packed {
		logic [NM_W-1:0]  nm;
		logic [NM_W-1:0]  dm;
		logic [NM_W-1:0]  rem;
		logic [NQ_W-1:0]  q;
		logic             neg;
		logic             sat;
		logic             ok;
		logic [LUX_W-1:0] lux;
	} nd_stage_t;

	nd_stage_t         stg_s [0:ND_STG];
	nd_stage_t         nxt   [0:ND_STG];
	logic [ND_STG:0]   vld_s;
	logic [ND_STG:0]   vprev;
	logic [ND_STG+1:0] ld;
	logic [NM_W-1:0]   nm;
	logic [NM_W-1:0]   dm;
	logic              pos;

	assign vprev = {vld_s[ND_STG-1:0], in_valid};
	assign pos   = din.xq >= X_OFF;
	assign nm    = pos ? NM_W'(din.xq - X_OFF) : NM_W'(X_OFF - din.xq);
	assign dm    = NM_W'(din.yq - Y_POLE);

	always_comb begin
		ld[ND_STG+1] = !out_stall;
		for (int k = ND_STG; k >= 0; k--) begin
			ld[k] = !vld_s[k] || ld[k+1];
		end
	end

	always_comb begin
		nd_stage_t d;
		logic [NM_W:0] rr;
		logic [NM_W+FRAC_W-1:0] dvd;
		d   = '0;
		rr  = '0;
		dvd = '0;
		// denominator 0.1858 - y is negative, so n takes the opposite sign of x - 0.332
		nxt[0].nm  = nm;
		nxt[0].dm  = dm;
		nxt[0].rem = NM_W'(nm >> (NQ_W - FRAC_W));
		nxt[0].q   = '0;
		nxt[0].neg = pos && (nm != '0);
		nxt[0].sat = NQ_W'(nm) >= {dm, {(NQ_W - NM_W){1'b0}}};
		nxt[0].ok  = din.ok && (din.yq >= Y_MIN);
		nxt[0].lux = din.lux;
		for (int k = 1; k <= ND_STG; k++) begin
			d   = stg_s[k-1];
			dvd = {d.nm, {FRAC_W{1'b0}}};
			for (int t = 0; t < STEPS; t++) begin
				if ((k - 1) * STEPS + t < NQ_W) begin
					rr = {d.rem, dvd[NQ_W - 1 - ((k - 1) * STEPS + t)]};
					if (rr >= {1'b0, d.dm}) begin
						rr  = rr - {1'b0, d.dm};
						d.q = {d.q[NQ_W-2:0], 1'b1};
					end else begin
						d.q = {d.q[NQ_W-2:0], 1'b0};
					end
					d.rem = rr[NM_W-1:0];
				end
			end
			nxt[k] = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k <= ND_STG; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vprev[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k <= ND_STG; k++) begin
			if (ld[k]) begin
				stg_s[k] <= nxt[k];
			end
		end
	end

	assign in_stall  = !ld[0];
	assign out_valid = vld_s[ND_STG];
	assign res.mag   = (stg_s[ND_STG].sat || stg_s[ND_STG].q > NLIM) ? NLIM : stg_s[ND_STG].q;
	assign res.neg   = stg_s[ND_STG].neg;
	assign res.ok    = stg_s[ND_STG].ok;
	assign res.lux   = stg_s[ND_STG].lux;
endmodule
`default_nettype wire

>>> sv/xct_poly.sv
// pipelined cubic, scaling by 1/100 and saturation
`default_nettype none
module xct_poly
	import xct_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  nval_t            din,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [LUX_W-1:0] lux,
	output logic [KEL_W-1:0] kelvin,
	output logic             kelvin_ok
);
	typedef struct packed {
		logic             neg;
		logic             ok;
		logic [LUX_W-1:0] lux;
	} side_t;

	logic [P_STG-1:0] vld_s;
	logic [P_STG-1:0] vprev;
	logic [P_STG:0]   ld;
	side_t            sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7, sd_s8;

	logic [NQ_W-1:0]  m_s1, m_s2;
	logic [SQ_W-1:0]  sq_s2;
	logic [P3_W-1:0]  p3_s3;
	logic [T1_W-1:0]  t1_s3, t1_s4;
	logic [T2_W-1:0]  t2_s3, t2_s4;
	logic [T3_W-1:0]  t3_s4;
	logic [ACC_W-1:0] acc_s5;
	logic [B_W-1:0]   b_s6;
	logic             kneg_s6, kneg_s7, kneg_s8;
	logic             sat_s7, sat_s8;
	logic [C_W-1:0]   c_s7, c_s8;
	logic [PR_W-1:0]  pr_s8;

	logic [N2_W-1:0]  n2;
	logic [N3_W-1:0]  n3;
	logic [ACC_W-1:0] acc;
	logic [ACC_W-1:0] amag;
	logic [QE_W-1:0]  qe;
	logic [C_W-1:0]   rmd;
	logic [KEL_W-1:0] qk;
	logic [KEL_W-1:0] kel;

	assign vprev = {vld_s[P_STG-2:0], in_valid};

	always_comb begin
		ld[P_STG] = !out_stall;
		for (int k = P_STG - 1; k >= 0; k--) begin
			ld[k] = !vld_s[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < P_STG; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vprev[k];
				end
			end
		end
	end

	assign n2 = sq_s2[SQ_W-1:FRAC_W];
	assign n3 = p3_s3[P3_W-1:FRAC_W];

	always_comb begin
		acc = C0 + ACC_W'(t2_s4);
		acc = sd_s4.neg ? acc - ACC_W'(t3_s4) - ACC_W'(t1_s4)
			: acc + ACC_W'(t3_s4) + ACC_W'(t1_s4);
	end

	assign amag = acc_s5[ACC_W-1] ? -acc_s5 : acc_s5;

	// quotient by 25 from the reciprocal can come out one low
	assign qe  = pr_s8[PR_W-1:RECIP_SH];
	assign rmd = c_s8 - C_W'(qe) * DIV_Q;
	assign qk  = KEL_W'(qe) + KEL_W'(rmd >= DIV_Q);

	always_comb begin
		if (!sd_s8.ok) begin
			kel = '0;
		end else if (sat_s8) begin
			kel = kneg_s8 ? KMIN : KMAX;
		end else begin
			kel = kneg_s8 ? -qk : qk;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			m_s1  <= din.mag;
			sd_s1 <= '{neg: din.neg, ok: din.ok, lux: din.lux};
		end
		if (ld[1]) begin
			sq_s2 <= SQ_W'(m_s1) * SQ_W'(m_s1);
			m_s2  <= m_s1;
			sd_s2 <= sd_s1;
		end
		if (ld[2]) begin
			p3_s3 <= P3_W'(n2) * P3_W'(m_s2);
			t2_s3 <= T2_W'(n2) * K2;
			t1_s3 <= T1_W'(m_s2) * K1;
			sd_s3 <= sd_s2;
		end
		if (ld[3]) begin
			t3_s4 <= T3_W'(n3) * K3;
			t2_s4 <= t2_s3;
			t1_s4 <= t1_s3;
			sd_s4 <= sd_s3;
		end
		if (ld[4]) begin
			acc_s5 <= acc;
			sd_s5  <= sd_s4;
		end
		if (ld[5]) begin
			b_s6    <= amag[ACC_W-1:FRAC_W];
			kneg_s6 <= acc_s5[ACC_W-1];
			sd_s6   <= sd_s5;
		end
		if (ld[6]) begin
			sat_s7  <= b_s6 >= SAT_B;
			c_s7    <= b_s6[C_W+1:2];
			kneg_s7 <= kneg_s6;
			sd_s7   <= sd_s6;
		end
		if (ld[7]) begin
			pr_s8   <= PR_W'(c_s7) * PR_W'(RECIP);
			c_s8    <= c_s7;
			sat_s8  <= sat_s7;
			kneg_s8 <= kneg_s7;
			sd_s8   <= sd_s7;
		end
	end

	assign in_stall  = !ld[0];
	assign out_valid = vld_s[P_STG-1];
	assign lux       = sd_s8.lux;
	assign kelvin    = kel;
	assign kelvin_ok = sd_s8.ok;
endmodule
`default_nettype wire

>>> sv/xyz_to_color_temperature.sv
// top level: XYZ counts to lux and McCamy color temperature
//
//  channel | signals                                      | direction
//  in      | in_valid in_stall x/y/z_count x/y/z_ok       | sensor beat into block
//  out     | out_valid out_stall lux kelvin kelvin_ok      | result beat out of block
//
// one beat per cycle sustained while out_stall stays low; a beat passes the chromaticity divider,
// the slope divider, then the cubic and scaling stages (dividers 3 bits a stage)
// a beat with y_ok low is taken and produces no result
// reset clears all valid bits, payload registers are not reset
// a stalled output lets empty stages upstream keep filling; in_stall rises only when full
`default_nettype none
module xyz_to_color_temperature
	import xct_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CNT_W-1:0] x_count,
	input  logic [CNT_W-1:0] y_count,
	input  logic [CNT_W-1:0] z_count,
	input  logic             x_ok,
	input  logic             y_ok,
	input  logic             z_ok,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [LUX_W-1:0] lux,
	output logic [KEL_W-1:0] kelvin,
	output logic             kelvin_ok
);
	chroma_t ch;
	nval_t   nv;
	logic    ch_valid, ch_stall;
	logic    nv_valid, nv_stall;

	xct_chroma u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid && y_ok),
		.in_stall  (in_stall),
		.xc        (x_count),
		.yc        (y_count),
		.zc        (z_count),
		.xv        (x_ok),
		.zv        (z_ok),
		.out_valid (ch_valid),
		.out_stall (ch_stall),
		.res       (ch)
	);

	xct_ndiv u_ndiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ch_valid),
		.in_stall  (ch_stall),
		.din       (ch),
		.out_valid (nv_valid),
		.out_stall (nv_stall),
		.res       (nv)
	);

	xct_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nv_valid),
		.in_stall  (nv_stall),
		.din       (nv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.lux       (lux),
		.kelvin    (kelvin),
		.kelvin_ok (kelvin_ok)
	);
endmodule
`default_nettype wire

>>> sv/xct_checker.sv
// port-level checks for the color temperature block
`default_nettype none
`include "xyz_to_color_temperature_assert.svh"
module xct_port_checks
	import xct_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [KEL_W-1:0] kelvin,
	input logic             kelvin_ok
);
	`XCT_ASSERT_NOW(a_kel_zero, out_valid && !kelvin_ok, kelvin == '0, "kelvin not zero when invalid")
	`XCT_ASSERT_NOW(a_full_stall, in_stall, out_valid && out_stall, "input stalled with room left")
	`XCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
	`XCT_ASSERT_NEXT(a_kel_hold, out_valid && out_stall, $stable(kelvin), "kelvin moved under stall")
endmodule

bind xyz_to_color_temperature xct_port_checks u_chk (.*);
`default_nettype wire
